/* rtl/core/med_pkg.sv */
package med_pkg;

  localparam int DURATION_BITS_DEF = 25;

  localparam int SPEED_W  = 12;
  localparam int WEIGHT_W = 8;
  localparam int SYM_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_OVERALL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARACTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd2;

  localparam logic [SPEED_W-1:0]  OVERALL_RST   = 12'd320;
  localparam logic [SPEED_W-1:0]  CHARACTER_RST = 12'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 8'd128;

  localparam logic [SPEED_W-1:0]  SPEED_MIN  = 12'd16;
  localparam logic [SPEED_W-1:0]  SPEED_MAX  = 12'd1920;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 8'd64;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'd192;

  localparam logic [SYM_W-1:0] SYM_DIT   = 3'd0;
  localparam logic [SYM_W-1:0] SYM_DAH   = 3'd1;
  localparam logic [SYM_W-1:0] SYM_INTRA = 3'd2;
  localparam logic [SYM_W-1:0] SYM_CHAR  = 3'd3;
  localparam logic [SYM_W-1:0] SYM_WORD  = 3'd4;

  // datapath widths
  localparam int CWS_W = 11;            // clamped speed, <= 1920
  localparam int KC_W  = 28;            // numerator constant
  localparam int X_W   = 21;            // numerator operand, <= 1152000
  localparam int CWW_W = 22;            // cw * w
  localparam int N_W   = 45;            // numerator
  localparam int DVD_W = 47;            // 2n + den
  localparam int DSR_W = 28;            // 2 * den
  localparam int QUO_W = 25;            // quotient always below 2^25

  typedef struct packed {
    logic [DVD_W-1:0] rem;
    logic [DSR_W-1:0] dsr;
    logic [QUO_W-1:0] quo;
    logic             known;
  } med_div_t;

endpackage

/* rtl/core/med_in_if.sv */
interface med_in_if;
  logic                     valid;
  logic                     ready;
  logic [med_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

/* rtl/core/med_out_if.sv */
interface med_out_if #(
  parameter int DURATION_BITS = med_pkg::DURATION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [DURATION_BITS-1:0] duration_us;
  logic                     symbol_known;

  modport source (output valid, output duration_us, output symbol_known, input ready);
  modport sink   (input valid, input duration_us, input symbol_known, output ready);
endinterface

/* rtl/core/med_prep.sv */
module med_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [med_pkg::SYM_W-1:0]        in_symbol,
  input  logic [med_pkg::SPEED_W-1:0]      overall_speed,
  input  logic [med_pkg::SPEED_W-1:0]      character_speed,
  input  logic [med_pkg::WEIGHT_W-1:0]     mark_weight,
  output logic                             out_valid,
  input  logic                             out_ready,
  output med_pkg::med_div_t                out_data
);

  logic [med_pkg::SPEED_W-1:0]  w, cmax, cw;
  logic [med_pkg::WEIGHT_W-1:0] q;
  logic                         farns;
  logic [20:0]                  pos, neg, dly;
  logic [med_pkg::KC_W-1:0]     kc;
  logic [med_pkg::X_W-1:0]      x;
  logic                         use_cww, known;

  logic                         v1_r, v2_r, v3_r;
  logic                         r1, r2, r3;
  logic [med_pkg::KC_W-1:0]     kc_r;
  logic [med_pkg::X_W-1:0]      x_r;
  logic [med_pkg::CWS_W-1:0]    cw1_r;
  logic [med_pkg::CWW_W-1:0]    cww_r;
  logic                         use_cww_r, known1_r, known2_r;
  logic [med_pkg::N_W-1:0]      n_r;
  logic [26:0]                  den_r;
  logic [48:0]                  prod;
  med_pkg::med_div_t            d3_r;

  always_comb begin
    w = overall_speed;
    if (w < med_pkg::SPEED_MIN) w = med_pkg::SPEED_MIN;
    if (w > med_pkg::SPEED_MAX) w = med_pkg::SPEED_MAX;
    farns = character_speed > w;
    cmax = farns ? character_speed : w;
    cw = (cmax > med_pkg::SPEED_MAX) ? med_pkg::SPEED_MAX : cmax;
    q = mark_weight;
    if (q < med_pkg::WEIGHT_MIN) q = med_pkg::WEIGHT_MIN;
    if (q > med_pkg::WEIGHT_MAX) q = med_pkg::WEIGHT_MAX;
    pos = 21'(cw) * 21'd600;
    neg = 21'(w) * 21'd372;
    dly = (pos > neg) ? pos - neg : 21'd0;
    kc = '0;
    x = '0;
    use_cww = 1'b0;
    known = 1'b1;
    unique case (in_symbol)
      med_pkg::SYM_DIT: begin
        kc = 28'd150000;
        x = med_pkg::X_W'(q);
      end
      med_pkg::SYM_DAH: begin
        kc = 28'd450000;
        x = med_pkg::X_W'(q);
      end
      med_pkg::SYM_INTRA: begin
        kc = 28'd150000;
        x = med_pkg::X_W'(9'd256 - 9'(q));
      end
      med_pkg::SYM_CHAR: begin
        kc = farns ? 28'd4800000 : 28'd57600000;
        x = farns ? dly : 21'd1;
        use_cww = farns;
      end
      med_pkg::SYM_WORD: begin
        kc = farns ? 28'd11200000 : 28'd134400000;
        x = farns ? dly : 21'd1;
        use_cww = farns;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign r3 = !v3_r || out_ready;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign in_ready = r1;
  assign prod = 49'(kc_r) * 49'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      kc_r      <= kc;
      x_r       <= x;
      cw1_r     <= cw[med_pkg::CWS_W-1:0];
      cww_r     <= med_pkg::CWW_W'(cw[med_pkg::CWS_W-1:0]) *
                   med_pkg::CWW_W'(w[med_pkg::CWS_W-1:0]);
      use_cww_r <= use_cww;
      known1_r  <= known;
    end
    if (r2) begin
      n_r      <= prod[med_pkg::N_W-1:0];
      den_r    <= use_cww_r ? 27'(cww_r) * 27'd19 : 27'(cw1_r);
      known2_r <= known1_r;
    end
    if (r3) begin
      d3_r.rem   <= {1'b0, n_r, 1'b0} + med_pkg::DVD_W'(den_r);
      d3_r.dsr   <= {den_r, 1'b0};
      d3_r.quo   <= '0;
      d3_r.known <= known2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

endmodule

/* rtl/core/med_cell.sv */
module med_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  med_pkg::med_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output med_pkg::med_div_t out_data
);

  localparam int CMP_W = med_pkg::DVD_W + med_pkg::DSR_W;

  logic              v_r;
  med_pkg::med_div_t d_r, d_nxt;
  logic [CMP_W-1:0]  sh, rem_ext;

  // one restoring-division step for quotient bit BIT
  always_comb begin
    sh = CMP_W'(in_data.dsr) << BIT;
    rem_ext = CMP_W'(in_data.rem);
    d_nxt = in_data;
    if (rem_ext >= sh) begin
      d_nxt.rem = in_data.rem - sh[med_pkg::DVD_W-1:0];
      d_nxt.quo[BIT] = 1'b1;
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) d_r <= d_nxt;
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

/* rtl/core/morse_element_duration_core.sv */
// Morse element duration: one symbol code in, its duration in microseconds out, derived
// from the overall speed, character speed and mark weight registers (PARIS timing with
// Farnsworth spacing). Fully pipelined, one item per cycle unless the output stalls:
// 3 front stages form the numerator and divisor, then 25 divider cells each settle one
// quotient bit. The last cell is the output register; a stall holds only as far back
// as stages are full.
module morse_element_duration_core #(
  parameter int DURATION_BITS = med_pkg::DURATION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  med_in_if.sink                             in_ch,
  med_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [med_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [med_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NC   = med_pkg::QUO_W;
  localparam int XW   = med_pkg::QUO_W + DURATION_BITS;
  localparam logic [XW-1:0] SAT = (XW'(1) << DURATION_BITS) - XW'(1);

  logic [med_pkg::SPEED_W-1:0]  overall_r, character_r;
  logic [med_pkg::WEIGHT_W-1:0] weight_r;

  logic              v   [NC+1];
  logic              rdy [NC+1];
  med_pkg::med_div_t dat [NC+1];
  logic [XW-1:0]     quo_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overall_r   <= med_pkg::OVERALL_RST;
      character_r <= med_pkg::CHARACTER_RST;
      weight_r    <= med_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        med_pkg::REG_OVERALL:   overall_r   <= cfg_wdata;
        med_pkg::REG_CHARACTER: character_r <= cfg_wdata;
        med_pkg::REG_WEIGHT:    weight_r    <= cfg_wdata[med_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  med_prep u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_symbol       (in_ch.symbol),
    .overall_speed   (overall_r),
    .character_speed (character_r),
    .mark_weight     (weight_r),
    .out_valid       (v[0]),
    .out_ready       (rdy[0]),
    .out_data        (dat[0])
  );

  // cell i resolves quotient bit NC-1-i, most significant first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    med_cell #(.BIT(NC-1-i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .in_data   (dat[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (dat[i+1])
    );
  end

  assign rdy[NC] = out_ch.ready;
  assign quo_ext = XW'(dat[NC].quo);

  assign out_ch.valid        = v[NC];
  assign out_ch.symbol_known = dat[NC].known;
  assign out_ch.duration_us  = (quo_ext > SAT) ? SAT[DURATION_BITS-1:0]
                                               : quo_ext[DURATION_BITS-1:0];

`ifndef NO_ASSERTIONS
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.symbol_known |-> out_ch.duration_us == '0)
    else $error("unknown symbol gave nonzero duration");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled while output side drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule

/* tb/sv/morse_element_duration_checker.sv */
module morse_element_duration_checker #(
  parameter int DURATION_BITS = med_pkg::DURATION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [med_pkg::SYM_W-1:0]      in_symbol,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [DURATION_BITS-1:0]       out_duration_us,
  input  logic                           out_symbol_known,
  input  logic                           cfg_we,
  input  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [med_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             pending,
  output int                             fail_count
);

  typedef struct packed {
    logic [DURATION_BITS-1:0] duration_us;
    logic                     known;
  } element_t;

  element_t                     expected_elements[$];
  logic [med_pkg::SPEED_W-1:0]  overall_q;
  logic [med_pkg::SPEED_W-1:0]  character_q;
  logic [med_pkg::WEIGHT_W-1:0] weight_q;

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned lo,
                                            longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic element_t element_duration(logic [med_pkg::SYM_W-1:0] sym);
    longint unsigned w, c, q, cw, dur, mul, pos, neg;
    element_t e;
    w   = clamp(overall_q, med_pkg::SPEED_MIN, med_pkg::SPEED_MAX);
    c   = character_q;
    q   = clamp(weight_q, med_pkg::WEIGHT_MIN, med_pkg::WEIGHT_MAX);
    cw  = clamp((c <= w) ? w : c, med_pkg::SPEED_MIN, med_pkg::SPEED_MAX);
    dur = 0;
    e.known = 1'b1;
    case (sym)
      med_pkg::SYM_DIT:   dur = round_div(150000 * q, cw);
      med_pkg::SYM_DAH:   dur = round_div(450000 * q, cw);
      med_pkg::SYM_INTRA: dur = round_div(150000 * (256 - q), cw);
      med_pkg::SYM_CHAR, med_pkg::SYM_WORD: begin
        mul = (sym == med_pkg::SYM_CHAR) ? 3 : 7;
        if (c > w) begin
          // Farnsworth spacing; a non-positive delay gives zero gaps
          pos = 600 * cw;
          neg = 372 * w;
          dur = (pos > neg) ? round_div(1600000 * mul * (pos - neg), 19 * cw * w) : 0;
        end else begin
          dur = round_div(19200000 * mul, cw);
        end
      end
      default: e.known = 1'b0;
    endcase
    if (dur > (64'd1 << DURATION_BITS) - 1) dur = (64'd1 << DURATION_BITS) - 1;
    e.duration_us = dur[DURATION_BITS-1:0];
    return e;
  endfunction

  assign pending = expected_elements.size();

  always @(posedge clk) begin
    element_t want;
    if (!rst_n) begin
      overall_q   <= med_pkg::OVERALL_RST;
      character_q <= med_pkg::CHARACTER_RST;
      weight_q    <= med_pkg::WEIGHT_RST;
      expected_elements.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) expected_elements.push_back(element_duration(in_symbol));
      if (out_valid && out_ready) begin
        if (expected_elements.size() == 0) begin
          $display("%0t: unexpected item dur=%0d known=%0d", $time, out_duration_us,
                   out_symbol_known);
          fail_count++;
        end else begin
          want = expected_elements.pop_front();
          if (want.duration_us !== out_duration_us) begin
            $display("%0t: duration_us expected %0d actual %0d", $time, want.duration_us,
                     out_duration_us);
            fail_count++;
          end
          if (want.known !== out_symbol_known) begin
            $display("%0t: symbol_known expected %0d actual %0d", $time, want.known,
                     out_symbol_known);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          med_pkg::REG_OVERALL:   overall_q   <= cfg_wdata[med_pkg::SPEED_W-1:0];
          med_pkg::REG_CHARACTER: character_q <= cfg_wdata[med_pkg::SPEED_W-1:0];
          med_pkg::REG_WEIGHT:    weight_q    <= cfg_wdata[med_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/sv/morse_element_duration_core_test.sv */
module morse_element_duration_core_test;

  localparam int DB = med_pkg::DURATION_BITS_DEF;
  localparam logic [med_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [med_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int pending, fail_count;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  med_in_if in_ch ();
  med_out_if #(.DURATION_BITS(DB)) out_ch ();

  morse_element_duration_core #(.DURATION_BITS(DB)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  morse_element_duration_checker #(.DURATION_BITS(DB)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_symbol(in_ch.symbol),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_duration_us(out_ch.duration_us), .out_symbol_known(out_ch.symbol_known),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // called at a rising edge; returns at the edge the item is taken
  task automatic send_symbol(input logic [med_pkg::SYM_W-1:0] sym);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [med_pkg::CFG_IDX_W-1:0] idx,
                           input logic [med_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int ov, input int ch, input int wt);
    wait_drained();
    write_reg(med_pkg::REG_OVERALL, med_pkg::CFG_DATA_W'(ov));
    write_reg(med_pkg::REG_CHARACTER, med_pkg::CFG_DATA_W'(ch));
    write_reg(med_pkg::REG_WEIGHT, med_pkg::CFG_DATA_W'(wt));
    write_reg(REG_UNUSED, med_pkg::CFG_DATA_W'($urandom));
  endtask

  function automatic logic [med_pkg::SYM_W-1:0] pick_symbol();
    return med_pkg::SYM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 4));
  endfunction

  initial begin
    int ov, ch;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.symbol = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every code at reset timing, then the five defined codes at the register extremes
    for (int s = 0; s < 8; s++) send_symbol(med_pkg::SYM_W'(s));
    set_timing(0, 0, 0);
    for (int s = 0; s < 5; s++) send_symbol(med_pkg::SYM_W'(s));
    set_timing(4095, 4095, 255);
    for (int s = 0; s < 5; s++) send_symbol(med_pkg::SYM_W'(s));
    set_timing(16, 4095, 12'hF40);
    for (int s = 0; s < 5; s++) send_symbol(med_pkg::SYM_W'(s));

    for (int phase = 0; phase < 18; phase++) begin
      send_idle_pct = (phase < 6) ? 29 : (phase < 12) ? 74 : 0;
      recv_idle_pct = (phase < 6) ? 74 : (phase < 12) ? 29 : 0;
      ov = (phase % 4 == 0) ? $urandom_range(0, 4095) : $urandom_range(10, 1930);
      case ($urandom_range(0, 2))
        0: ch = $urandom_range(0, ov);
        1: ch = $urandom_range(ov, 4095);
        default: ch = $urandom_range(0, 4095);
      endcase
      set_timing(ov, ch, $urandom_range(0, 4095));
      for (int i = 0; i < 105; i++) send_symbol(pick_symbol());
    end

    wait_drained();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* morse_element_duration_core.f */
rtl/core/med_pkg.sv
rtl/core/med_in_if.sv
rtl/core/med_out_if.sv
rtl/core/med_prep.sv
rtl/core/med_cell.sv
rtl/core/morse_element_duration_core.sv
tb/sv/morse_element_duration_checker.sv
tb/sv/morse_element_duration_core_test.sv
